// File: rtl/sprite_frame_sequencer_assert.svh
// Assertion macros for the sprite frame sequencer.
// No dependencies; the including module must provide clk and rst_n.
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sfs_pkg.sv
// Shared types, constants and helpers for the sprite frame sequencer.
// No dependencies.
`timescale 1ns / 1ps
package sfs_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int FRAME_BITS  = 16;
  localparam int FIELD_W     = 16;
  localparam int TIME_W      = 16;
  localparam int TIMER_W     = 32;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // request codes on the input channel
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_LOAD   = 2'd1;
  localparam logic [1:0] REQ_RESUME = 2'd2;

  typedef logic [1:0] op_t;
  localparam op_t OP_NOP    = 2'd0;
  localparam op_t OP_TICK   = 2'd1;
  localparam op_t OP_LOAD   = 2'd2;
  localparam op_t OP_RESUME = 2'd3;

  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef struct packed {
    frame_t            first;
    frame_t            last;
    logic [TIME_W-1:0] ms;
    logic              rep;
  } step_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    op_t  op;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] req_type;
  } sts_t;

  function automatic frame_t field_to_frame(input logic [FIELD_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[FRAME_BITS-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] frame_to_field(input frame_t f);
    logic [63:0] w;
    w = 64'(f);
    return w[FIELD_W-1:0];
  endfunction

endpackage

// File: rtl/sfs_ctrl.sv
// Transaction controller for the sprite frame sequencer.
// Depends on sfs_pkg; drives commands into sfs_datapath.
`timescale 1ns / 1ps
module sfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  sfs_pkg::sts_t sts,
  output sfs_pkg::cmd_t cmd
);
  import sfs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  op_t        op_dec;

  always_comb begin
    unique case (sts.req_type)
      REQ_TICK:   op_dec = OP_TICK;
      REQ_LOAD:   op_dec = OP_LOAD;
      REQ_RESUME: op_dec = OP_RESUME;
      default:    op_dec = OP_NOP;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = OP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.op    = op_dec;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESP);

endmodule

// File: rtl/sfs_datapath.sv
// Datapath for the sprite frame sequencer: item capture, step state,
// step queue memory and result registers. Depends on sfs_pkg and the assert header.
`timescale 1ns / 1ps
`include "sprite_frame_sequencer_assert.svh"
module sfs_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    in_req_type,
  input  logic [sfs_pkg::FIELD_W-1:0]   in_delta_ms,
  input  logic [sfs_pkg::FIELD_W-1:0]   in_start_frame,
  input  logic [sfs_pkg::FIELD_W-1:0]   in_last_frame,
  input  logic [sfs_pkg::TIME_W-1:0]    in_frame_time_ms,
  input  logic                          in_loop_step,
  input  logic                          in_first_of_sequence,
  input  sfs_pkg::cmd_t                 cmd,
  output sfs_pkg::sts_t                 sts,
  output logic [sfs_pkg::FIELD_W-1:0]   out_frame_index,
  output logic                          out_frame_advanced,
  output logic                          out_running,
  output logic                          out_finished,
  output logic                          out_status
);
  import sfs_pkg::*;

  // captured item
  logic [1:0]         req_r;
  logic [FIELD_W-1:0] dt_r;
  frame_t             sf_r;
  frame_t             ef_r;
  logic [TIME_W-1:0]  ft_r;
  logic               lp_r;
  logic               first_r;

  // step state
  logic               run_r, run_nxt;
  logic               fin_r, fin_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  frame_t             cur_r, cur_nxt;
  frame_t             start_r, start_nxt;
  frame_t             end_r, end_nxt;
  logic [TIME_W-1:0]  ftime_r, ftime_nxt;
  logic               loop_r, loop_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               changed_r, changed_nxt;
  logic               status_r, status_nxt;

  // queue memory
  step_t              queue_mem [QUEUE_DEPTH];
  step_t              rd_data_r;
  step_t              wr_data;
  logic [PTR_W-1:0]   wr_addr;
  logic               wr_en;

  logic [TIMER_W:0]   sum;
  logic [TIMER_W-1:0] timer_sat;
  logic [CNT_W:0]     slot_sum;
  logic [PTR_W-1:0]   head_inc;
  frame_t             offs;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      dt_r    <= in_delta_ms;
      sf_r    <= field_to_frame(in_start_frame);
      ef_r    <= field_to_frame(in_last_frame);
      ft_r    <= in_frame_time_ms;
      lp_r    <= in_loop_step;
      first_r <= in_first_of_sequence;
    end
  end

  assign sts.req_type = req_r;

  always_comb begin
    sum       = (TIMER_W+1)'(timer_r) + (TIMER_W+1)'(dt_r);
    timer_sat = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
    slot_sum  = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
    wr_addr   = (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH))
              ? PTR_W'(slot_sum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(slot_sum);
    head_inc  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    offs      = end_r - cur_r;
    wr_data   = '{first: sf_r, last: ef_r, ms: ft_r, rep: lp_r};
    wr_en     = 1'b0;

    run_nxt     = run_r;
    fin_nxt     = fin_r;
    timer_nxt   = timer_r;
    cur_nxt     = cur_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    ftime_nxt   = ftime_r;
    loop_nxt    = loop_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    changed_nxt = changed_r;
    status_nxt  = status_r;

    case (cmd.op)
      OP_TICK: begin
        changed_nxt = 1'b0;
        status_nxt  = 1'b0;
        if (run_r) begin
          timer_nxt = timer_sat;
          if (timer_sat >= TIMER_W'(ftime_r)) begin
            changed_nxt = 1'b1;
            timer_nxt   = '0;
            if (cur_r == end_r) begin
              if (loop_r) begin
                cur_nxt = start_r;
              end else if (count_r != '0) begin
                // take the next queued step, frame moves to its start
                start_nxt = rd_data_r.first;
                end_nxt   = rd_data_r.last;
                ftime_nxt = rd_data_r.ms;
                loop_nxt  = rd_data_r.rep;
                cur_nxt   = rd_data_r.first;
                head_nxt  = head_inc;
                count_nxt = count_r - CNT_W'(1);
              end else begin
                fin_nxt = 1'b1;
                run_nxt = 1'b0;
              end
            end else begin
              cur_nxt = cur_r + frame_t'(1);
            end
          end
        end
      end
      OP_LOAD: begin
        changed_nxt = 1'b0;
        status_nxt  = 1'b0;
        if (first_r) begin
          head_nxt  = '0;
          count_nxt = '0;
          start_nxt = sf_r;
          end_nxt   = ef_r;
          ftime_nxt = ft_r;
          loop_nxt  = lp_r;
          cur_nxt   = sf_r;
          timer_nxt = '0;
          run_nxt   = 1'b1;
          fin_nxt   = 1'b0;
        end else if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
          status_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_RESUME: begin
        changed_nxt = 1'b0;
        status_nxt  = 1'b0;
        head_nxt    = '0;
        count_nxt   = '0;
        cur_nxt     = sf_r + offs;
        start_nxt   = sf_r;
        end_nxt     = ef_r;
        run_nxt     = 1'b1;
        fin_nxt     = 1'b0;
      end
      default: begin
        // unknown request on execute: report state unchanged
        if (cmd.capture == 1'b0 && req_r != REQ_TICK && req_r != REQ_LOAD
            && req_r != REQ_RESUME) begin
          changed_nxt = 1'b0;
          status_nxt  = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      queue_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= queue_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      fin_r   <= 1'b0;
      timer_r <= '0;
      cur_r   <= '0;
      start_r <= '0;
      end_r   <= '0;
      ftime_r <= '0;
      loop_r  <= 1'b0;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      run_r   <= run_nxt;
      fin_r   <= fin_nxt;
      timer_r <= timer_nxt;
      cur_r   <= cur_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      ftime_r <= ftime_nxt;
      loop_r  <= loop_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    changed_r <= changed_nxt;
    status_r  <= status_nxt;
  end

  assign out_frame_index    = frame_to_field(cur_r);
  assign out_frame_advanced = changed_r;
  assign out_running        = run_r;
  assign out_finished       = fin_r;
  assign out_status         = status_r;

  `SFS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "queue count over depth")
  `SFS_ASSERT_NOW(a_run_fin_excl, fin_r, !run_r, "running and finished together")
  `SFS_ASSERT_NEXT(a_first_load, cmd.op == OP_LOAD && first_r, run_r && count_r == '0 && timer_r == '0, "first load did not start a fresh step")
  `SFS_ASSERT_NEXT(a_resume_clears, cmd.op == OP_RESUME, run_r && !fin_r && count_r == '0, "resume did not restart with empty queue")
  `SFS_ASSERT_NEXT(a_drop_only_full, cmd.op == OP_LOAD && !first_r && count_r != CNT_W'(QUEUE_DEPTH), !status_r, "step dropped while queue had room")

endmodule

// File: rtl/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: controller plus datapath.
// Depends on sfs_pkg, sfs_ctrl and sfs_datapath.
`timescale 1ns / 1ps
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------------
//  in_      | in_valid / in_stall  | req_type, delta_ms, start_frame, last_frame,
//           |                      | frame_time_ms, loop_step, first_of_sequence
//  out_     | out_valid / out_stall| frame_index, frame_advanced, running, finished,
//           |                      | status
//
//  One result transaction per input transaction, in order.
//  Each transaction passes through the sfs_ctrl states in order: capture,
//  execute (timer add, end compare, queue pop or push), then result presented.
//  The next input is taken in the cycle after the result leaves; no new item is
//  accepted before that, and the result is held while out_stall is high.
//  Reset is synchronous on rst_n (active low); step state and queue pointers clear,
//  the queue memory itself is not cleared (only counted entries are ever read).
//  in_stall is high after capture until the result transaction completes.
//
module sprite_frame_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  // input transactions
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [sfs_pkg::FIELD_W-1:0] in_delta_ms,
  input  logic [sfs_pkg::FIELD_W-1:0] in_start_frame,
  input  logic [sfs_pkg::FIELD_W-1:0] in_last_frame,
  input  logic [sfs_pkg::TIME_W-1:0]  in_frame_time_ms,
  input  logic                        in_loop_step,
  input  logic                        in_first_of_sequence,
  // result transactions
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sfs_pkg::FIELD_W-1:0] out_frame_index,
  output logic                        out_frame_advanced,
  output logic                        out_running,
  output logic                        out_finished,
  output logic                        out_status
);
  import sfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: sequences capture, execute and result hand-off.
  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: holds step state, the step queue and the result registers,
  // which stay put while out_stall is high.
  sfs_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_req_type          (in_req_type),
    .in_delta_ms          (in_delta_ms),
    .in_start_frame       (in_start_frame),
    .in_last_frame        (in_last_frame),
    .in_frame_time_ms     (in_frame_time_ms),
    .in_loop_step         (in_loop_step),
    .in_first_of_sequence (in_first_of_sequence),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_frame_index      (out_frame_index),
    .out_frame_advanced   (out_frame_advanced),
    .out_running          (out_running),
    .out_finished         (out_finished),
    .out_status           (out_status)
  );

endmodule

// File: test/sprite_frame_checker.sv
// Scoreboard for the sprite frame sequencer: watches both channels, predicts each result.
// Depends on sfs_pkg for frame and step types, queue depth and request codes.
`timescale 1ns / 1ps

module sprite_frame_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [sfs_pkg::FIELD_W-1:0] in_delta_ms,
  input  logic [sfs_pkg::FIELD_W-1:0] in_start_frame,
  input  logic [sfs_pkg::FIELD_W-1:0] in_last_frame,
  input  logic [sfs_pkg::TIME_W-1:0]  in_frame_time_ms,
  input  logic                        in_loop_step,
  input  logic                        in_first_of_sequence,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [sfs_pkg::FIELD_W-1:0] out_frame_index,
  input  logic                        out_frame_advanced,
  input  logic                        out_running,
  input  logic                        out_finished,
  input  logic                        out_status,
  output int                          mismatches,
  output int                          outstanding,
  output int                          compared
);
  import sfs_pkg::*;

  typedef struct {
    frame_t frame;
    logic   changed;
    logic   running;
    logic   finished;
    logic   status;
  } frame_report_t;

  frame_report_t expected_reports[$];

  // shadow of the sequencer state
  logic               anim_running;
  logic               anim_done;
  logic [TIMER_W-1:0] ms_acc;
  frame_t             frame_now;
  frame_t             step_first;
  frame_t             step_last;
  logic [TIME_W-1:0]  step_ms;
  logic               step_rep;
  step_t              step_ring [QUEUE_DEPTH];
  int                 ring_head;
  int                 ring_fill;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  function void advance_sequencer(input logic [1:0] kind, input logic [15:0] dt,
                                  input frame_t sf, input frame_t ef,
                                  input logic [TIME_W-1:0] ft, input logic lp,
                                  input logic fs);
    logic [TIMER_W:0] sum;
    frame_t           offs;
    step_t            nxt;
    frame_report_t    r;
    r.changed = 1'b0;
    r.status  = 1'b0;
    case (kind)
      REQ_TICK: begin
        if (anim_running) begin
          sum    = {1'b0, ms_acc} + (TIMER_W + 1)'(dt);
          ms_acc = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
          if (ms_acc >= TIMER_W'(step_ms)) begin
            if (frame_now == step_last) begin
              if (step_rep) begin
                frame_now = step_first;
              end else if (ring_fill != 0) begin
                // next queued step takes over, frame jumps to its start
                nxt        = step_ring[ring_head];
                ring_head  = (ring_head + 1) % QUEUE_DEPTH;
                ring_fill--;
                step_first = nxt.first;
                step_last  = nxt.last;
                step_ms    = nxt.ms;
                step_rep   = nxt.rep;
                frame_now  = nxt.first;
              end else begin
                anim_done    = 1'b1;
                anim_running = 1'b0;
              end
            end else begin
              frame_now = frame_now + 1'b1;
            end
            r.changed = 1'b1;
            ms_acc    = '0;
          end
        end
      end
      REQ_LOAD: begin
        if (fs) begin
          ring_head    = 0;
          ring_fill    = 0;
          step_first   = sf;
          step_last    = ef;
          step_ms      = ft;
          step_rep     = lp;
          frame_now    = sf;
          ms_acc       = '0;
          anim_running = 1'b1;
          anim_done    = 1'b0;
        end else if (ring_fill >= QUEUE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          step_ring[(ring_head + ring_fill) % QUEUE_DEPTH] = '{first: sf, last: ef,
                                                               ms: ft, rep: lp};
          ring_fill++;
        end
      end
      REQ_RESUME: begin
        offs         = step_last - frame_now;
        ring_head    = 0;
        ring_fill    = 0;
        frame_now    = sf + offs;
        step_first   = sf;
        step_last    = ef;
        anim_running = 1'b1;
        anim_done    = 1'b0;
      end
      default: ;
    endcase
    r.frame    = frame_now;
    r.running  = anim_running;
    r.finished = anim_done;
    expected_reports.push_back(r);
  endfunction

  always @(posedge clk) begin
    frame_report_t want;
    if (!rst_n) begin
      anim_running = 1'b0;
      anim_done    = 1'b0;
      ms_acc       = '0;
      frame_now    = '0;
      step_first   = '0;
      step_last    = '0;
      step_ms      = '0;
      step_rep     = 1'b0;
      ring_head    = 0;
      ring_fill    = 0;
      expected_reports.delete();
      mismatches   = 0;
      compared     = 0;
    end else begin
      if (in_valid && !in_stall)
        advance_sequencer(in_req_type, in_delta_ms, in_start_frame, in_last_frame,
                          in_frame_time_ms, in_loop_step, in_first_of_sequence);
      if (out_valid && !out_stall) begin
        compared++;
        if (expected_reports.size() == 0) begin
          report("unexpected result transaction", out_frame_index, 0);
        end else begin
          want = expected_reports.pop_front();
          if (out_frame_index !== want.frame)
            report("frame_index", out_frame_index, want.frame);
          if (out_frame_advanced !== want.changed)
            report("frame_advanced", out_frame_advanced, want.changed);
          if (out_running !== want.running)
            report("running", out_running, want.running);
          if (out_finished !== want.finished)
            report("finished", out_finished, want.finished);
          if (out_status !== want.status)
            report("status", out_status, want.status);
        end
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

// File: test/tb_sprite_frame_sequencer.sv
// Stimulus and verdict for the sprite frame sequencer: directed corners, then random sequences.
// Depends on sfs_pkg, sprite_frame_sequencer and sprite_frame_checker.
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer;
  import sfs_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;   // undefined request code, must be ignored
  localparam int         N_ITEMS    = 950;
  localparam int         CYCLE_CAP  = 300000; // far above the slowest legal run
  localparam int         HOLD_LEN   = 120;    // cycles of the long receiver hold-off

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_req_type = REQ_TICK;
  logic [FIELD_W-1:0]  in_delta_ms = '0;
  logic [FIELD_W-1:0]  in_start_frame = '0;
  logic [FIELD_W-1:0]  in_last_frame = '0;
  logic [TIME_W-1:0]   in_frame_time_ms = '0;
  logic                in_loop_step = 1'b0;
  logic                in_first_of_sequence = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [FIELD_W-1:0]  out_frame_index;
  logic                out_frame_advanced;
  logic                out_running;
  logic                out_finished;
  logic                out_status;

  int mismatches;
  int outstanding;
  int compared;
  int sent = 0;
  int cycles = 0;
  int hold_req = 0;          // bumped by the stimulus to ask for a long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  logic recv_quiet = 1'b0;   // receiver never stalls while set
  bit   send_quiet = 1'b0;   // sender adds no random idle cycles while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_frame_sequencer dut (.*);

  sprite_frame_checker scoreboard (.*);

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, outstanding);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side back-pressure. A hold-off request overrides everything but reset for
  // the whole HOLD_LEN hold-off; otherwise roughly 29 % random stall unless told to stay quiet.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (recv_quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 29);
    end
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // Mostly short frame times so steps actually reach their end frame.
  function automatic logic [15:0] pick_frame_ms();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 13) return rnd16();
    return 16'($urandom_range(30, 1));
  endfunction

  function automatic logic [15:0] pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return rnd16();
    if (r < 8)  return 16'hFFFF;
    return 16'($urandom_range(25, 0));
  endfunction

  // One input transaction: optional random idle cycles, then offer and wait
  // until it is taken. Returns on the edge at which it was accepted.
  task automatic send(input logic [1:0] kind, input logic [15:0] dt, input logic [15:0] sf,
                      input logic [15:0] ef, input logic [15:0] ft, input logic lp,
                      input logic fs);
    while (!send_quiet && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_req_type          <= kind;
    in_delta_ms          <= dt;
    in_start_frame       <= sf;
    in_last_frame        <= ef;
    in_frame_time_ms     <= ft;
    in_loop_step         <= lp;
    in_first_of_sequence <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Unused fields carry random content: the block must ignore them.
  task automatic tick(input logic [15:0] dt);
    send(REQ_TICK, dt, rnd16(), rnd16(), rnd16(), 1'($urandom), 1'($urandom));
  endtask

  task automatic load(input logic fs, input logic [15:0] sf, input logic [15:0] ef,
                      input logic [15:0] ft, input logic lp);
    send(REQ_LOAD, rnd16(), sf, ef, ft, lp, fs);
  endtask

  task automatic resume(input logic [15:0] sf, input logic [15:0] ef);
    send(REQ_RESUME, rnd16(), sf, ef, rnd16(), 1'($urandom), 1'($urandom));
  endtask

  // Sender stops and waits for every owed result to come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // A well-formed animation: first step, a few queued steps, a run of ticks,
  // sometimes a resume part way. Ranges are short so steps really end.
  task automatic play_sequence();
    logic [15:0] s;
    int          n;
    s = rnd16();
    load(1'b1, s, s + 16'($urandom_range(4)), pick_frame_ms(), ($urandom_range(99) < 20));
    n = $urandom_range(4);
    repeat (n) begin
      s = rnd16();
      load(1'b0, s, ($urandom_range(9) == 0) ? rnd16() : s + 16'($urandom_range(4)),
           pick_frame_ms(), ($urandom_range(99) < 15));
    end
    n = $urandom_range(25, 5);
    repeat (n) begin
      if ($urandom_range(99) < 4) begin
        s = rnd16();
        resume(s, s + 16'($urandom_range(5)));
      end else begin
        tick(pick_delta());
      end
    end
  endtask

  // Broken or hostile traffic: overflowing the queue, ticks with nothing
  // loaded, or fully random transactions including the undefined code.
  task automatic play_noise();
    int r;
    r = $urandom_range(99);
    if (r < 30) begin
      repeat ($urandom_range(11, 7))
        load(1'b0, rnd16(), rnd16(), pick_frame_ms(), 1'($urandom));
    end else if (r < 50) begin
      repeat ($urandom_range(6, 1)) tick(pick_delta());
    end else begin
      repeat ($urandom_range(6, 1))
        send(2'($urandom_range(3)), rnd16(), rnd16(), rnd16(), rnd16(),
             1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    bit held;
    held = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed corners ----
    tick(16'hFFFF);                                        // tick while stopped
    send(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    load(1'b0, 16'd10, 16'd11, 16'd5, 1'b0);               // queued while stopped
    load(1'b1, 16'hFFFE, 16'h0001, 16'h0000, 1'b0);        // start past end, zero frame time
    repeat (4) tick(16'h0000);                             // wraps through 0, then next step
    tick(16'd3);                                           // below frame time
    tick(16'd2);                                           // reaches it
    tick(16'hFFFF);                                        // finishing advance
    tick(16'd1);                                           // stopped again
    resume(16'd100, 16'hFFFF);
    load(1'b1, 16'd5, 16'd5, 16'hFFFF, 1'b1);              // single-frame looping step
    repeat (9) load(1'b0, rnd16(), rnd16(), rnd16(), 1'($urandom)); // last one dropped
    tick(16'hFFFF);                                        // loop back to start
    resume(16'hFFFF, 16'h0000);
    drain();                                               // sender waits for all results

    // ---- random sequences ----
    while (sent < N_ITEMS) begin
      if (!held && sent >= 300) begin
        // long hold-off on the result side while transactions keep coming
        held = 1'b1;
        hold_req <= hold_req + 1;
      end
      if (sent >= 500 && sent < 650) begin
        send_quiet = 1'b1;
        recv_quiet <= 1'b1;
      end else begin
        send_quiet = 1'b0;
        recv_quiet <= 1'b0;
      end
      if ($urandom_range(99) < 75)
        play_sequence();
      else
        play_noise();
      if ($urandom_range(19) == 0)
        drain();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d input transactions and %0d compared results:", sent, compared);
    $display("  wrap-around ranges, queue overflow, resume, looping and finishing steps.");
    if (mismatches == 0 && outstanding == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/sfs_pkg.sv
rtl/sfs_ctrl.sv
rtl/sfs_datapath.sv
rtl/sprite_frame_sequencer.sv
test/sprite_frame_checker.sv
test/tb_sprite_frame_sequencer.sv
